/* rtl/tilt_pkg.sv */
// Shared types and constants for the accelerometer tilt filter.
// Used by the CORDIC/sqrt unit and the top level.
package tilt_pkg;

    localparam int AccW = 18;
    localparam int AngW = 17;
    localparam int TabLen = 24;
    localparam logic signed [AccW-1:0] AccLimit = 18'sd81920;
    localparam logic signed [AngW-1:0] AngLimit = 17'sd46080;
    localparam logic signed [AngW-1:0] RightAngle = 17'sd23040;
    localparam logic [19:0] ScaleQ16 = 20'd642947;

    localparam logic [2:0] REG_ERR_X = 3'd0;
    localparam logic [2:0] REG_ERR_Y = 3'd1;
    localparam logic [2:0] REG_ERR_Z = 3'd2;
    localparam logic [2:0] REG_ROLL_ERR = 3'd3;
    localparam logic [2:0] REG_PITCH_ERR = 3'd4;
    localparam logic [2:0] REG_GAIN = 3'd5;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:  atan_entry = 22'd2949120;
            5'd1:  atan_entry = 22'd1740967;
            5'd2:  atan_entry = 22'd919879;
            5'd3:  atan_entry = 22'd466945;
            5'd4:  atan_entry = 22'd234379;
            5'd5:  atan_entry = 22'd117304;
            5'd6:  atan_entry = 22'd58666;
            5'd7:  atan_entry = 22'd29335;
            5'd8:  atan_entry = 22'd14668;
            5'd9:  atan_entry = 22'd7334;
            5'd10: atan_entry = 22'd3667;
            5'd11: atan_entry = 22'd1833;
            5'd12: atan_entry = 22'd917;
            5'd13: atan_entry = 22'd458;
            5'd14: atan_entry = 22'd229;
            5'd15: atan_entry = 22'd115;
            5'd16: atan_entry = 22'd57;
            5'd17: atan_entry = 22'd29;
            5'd18: atan_entry = 22'd14;
            5'd19: atan_entry = 22'd7;
            5'd20: atan_entry = 22'd4;
            5'd21: atan_entry = 22'd2;
            5'd22: atan_entry = 22'd1;
            default: atan_entry = 22'd0;
        endcase
    endfunction

    function automatic logic signed [AccW-1:0] sat_acc(input logic signed [19:0] v);
        if (v > 20'(AccLimit)) sat_acc = AccLimit;
        else if (v < -20'(AccLimit)) sat_acc = -AccLimit;
        else sat_acc = v[AccW-1:0];
    endfunction

    function automatic logic signed [AngW-1:0] sat_ang(input logic signed [23:0] v);
        if (v > 24'(AngLimit)) sat_ang = AngLimit;
        else if (v < -24'(AngLimit)) sat_ang = -AngLimit;
        else sat_ang = v[AngW-1:0];
    endfunction

endpackage

/* rtl/tilt_angle_unit.sv */
// Iterative tilt angle unit: bitwise square root followed by CORDIC vectoring.
// Depends on tilt_pkg for the angle table.
module tilt_angle_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [tilt_pkg::AccW-1:0]  num,
    input  logic signed [tilt_pkg::AccW-1:0]  a_in,
    input  logic signed [tilt_pkg::AccW-1:0]  b_in,
    output logic                              done,
    output logic signed [tilt_pkg::AngW-1:0]  angle
);
    typedef enum logic [2:0] {S_IDLE, S_SQA, S_SQB, S_ROOT, S_CORD, S_END} state_t;
    localparam int Steps = (CORDIC_STEPS < tilt_pkg::TabLen) ? CORDIC_STEPS : tilt_pkg::TabLen;

    state_t state_reg;
    logic [4:0] cnt_reg;
    logic signed [tilt_pkg::AccW-1:0] num_reg, b_reg;
    logic [26:0] rem_reg;
    logic [26:0] res_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic signed [tilt_pkg::AngW-1:0] angle_reg;
    logic done_reg;

    // One restoring square-root digit per cycle over a 54-bit radicand.
    logic [53:0] rad_reg;
    logic [28:0] trial;
    logic [28:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg, rad_reg[53:52]};
        trial = {res_reg, 2'b01};
    end

    logic signed [35:0] sq;
    assign sq = 36'(a_in) * 36'(a_in);
    logic signed [35:0] sqb;
    assign sqb = 36'(b_reg) * 36'(b_reg);

    logic signed [35:0] dx, dy;
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    logic signed [31:0] zr;
    assign zr = (z_reg + 32'sd128) >>> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (start) begin
                    num_reg <= num;
                    b_reg <= b_in;
                    rad_reg <= {18'd0, sq};
                    state_reg <= S_SQB;
                end
                S_SQB: begin
                    rad_reg <= {rad_reg[37:0] + sqb[37:0] , 16'd0};
                    rem_reg <= '0;
                    res_reg <= '0;
                    cnt_reg <= 5'd0;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (rem_sh >= trial) begin
                        rem_reg <= 27'(rem_sh - trial);
                        res_reg <= {res_reg[25:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[26:0];
                        res_reg <= {res_reg[25:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[51:0], 2'b00};
                    if (cnt_reg == 5'd26) begin
                        cnt_reg <= 5'd0;
                        state_reg <= S_SQA;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SQA: begin
                    x_reg <= 36'(res_reg);
                    y_reg <= 36'(num_reg) <<< 8;
                    z_reg <= '0;
                    if (res_reg == '0) begin
                        if (num_reg > 0) angle_reg <= tilt_pkg::RightAngle;
                        else if (num_reg < 0) angle_reg <= -tilt_pkg::RightAngle;
                        else angle_reg <= '0;
                        state_reg <= S_END;
                    end else begin
                        state_reg <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + 32'(tilt_pkg::atan_entry(cnt_reg));
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - 32'(tilt_pkg::atan_entry(cnt_reg));
                    end
                    if (cnt_reg == 5'(Steps - 1)) state_reg <= S_END;
                    else cnt_reg <= cnt_reg + 5'd1;
                end
                S_END: begin
                    if (res_reg != '0) angle_reg <= zr[tilt_pkg::AngW-1:0];
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign done = done_reg;
    assign angle = angle_reg;

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held two cycles");
    a_root_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROOT |-> cnt_reg <= 5'd26) else $error("root count overrun");
    a_angle_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (angle_reg <= 17'sd23100 && angle_reg >= -17'sd23100))
        else $error("angle out of range");
`endif
endmodule

/* rtl/accel_tilt_angle_filter.sv */
// Accelerometer tilt filter: one sample in, corrected axes plus roll/pitch out.
// Steps from input to output transaction: scaling of the three axes in the shared multiplier,
// two passes of the shared sqrt/CORDIC unit (roll, then pitch), then the roll and pitch filters.
// One item in flight; a new input is taken only once the last result has left the output,
// and an angle with a zero denominator skips its CORDIC rotations.
// aresetn is synchronous: registers return to reset values, filters clear.
module accel_tilt_angle_filter #(
    parameter int CORDIC_STEPS = 16,
    parameter int FILTER_EXTRA_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // raw_x[12:0], raw_y[25:13], raw_z[38:26]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // accel_x, accel_y, accel_z, roll_angle, pitch_angle,
                                    // roll_smoothed, pitch_smoothed
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [16:0]  cfg_data
);
    localparam int E = FILTER_EXTRA_BITS;
    localparam int FW = tilt_pkg::AngW + E + 2;

    typedef enum logic [2:0] {S_IDLE, S_SCALE, S_ROLL, S_PITCH, S_FILT, S_OUT} state_t;

    logic signed [16:0] err_x_reg, err_y_reg, err_z_reg;
    logic signed [15:0] roll_err_reg, pitch_err_reg;
    logic [15:0] gain_reg;

    state_t state_reg;
    logic [1:0] ax_reg;
    logic started_reg;
    logic signed [12:0] raw_reg [3];
    logic signed [tilt_pkg::AccW-1:0] acc_reg [3];
    logic signed [tilt_pkg::AngW-1:0] roll_reg, pitch_reg, rs_reg, ps_reg;
    logic signed [FW-1:0] racc_reg, pacc_reg;
    logic fsel_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_x_reg <= '0; err_y_reg <= '0; err_z_reg <= '0;
            roll_err_reg <= '0; pitch_err_reg <= '0; gain_reg <= 16'd3932;
        end else if (cfg_valid) begin
            case (cfg_index)
                tilt_pkg::REG_ERR_X: err_x_reg <= cfg_data;
                tilt_pkg::REG_ERR_Y: err_y_reg <= cfg_data;
                tilt_pkg::REG_ERR_Z: err_z_reg <= cfg_data;
                tilt_pkg::REG_ROLL_ERR: roll_err_reg <= cfg_data[15:0];
                tilt_pkg::REG_PITCH_ERR: pitch_err_reg <= cfg_data[15:0];
                tilt_pkg::REG_GAIN: gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Shared scale multiplier, one axis per cycle.
    logic signed [16:0] err_sel;
    logic signed [33:0] prod;
    logic signed [19:0] scaled;
    always_comb begin
        case (ax_reg)
            2'd0: err_sel = err_x_reg;
            2'd1: err_sel = err_y_reg;
            default: err_sel = err_z_reg;
        endcase
        prod = 34'(raw_reg[ax_reg]) * $signed({1'b0, tilt_pkg::ScaleQ16}) + 34'sd32768;
        scaled = 20'(prod >>> 16) - 20'(err_sel);
    end

    logic unit_start, unit_done;
    logic signed [tilt_pkg::AccW-1:0] u_num, u_a, u_b;
    logic signed [tilt_pkg::AngW-1:0] u_angle;
    always_comb begin
        if (state_reg == S_ROLL) begin
            u_num = acc_reg[1]; u_a = acc_reg[0]; u_b = acc_reg[2];
        end else begin
            u_num = -acc_reg[0]; u_a = acc_reg[1]; u_b = acc_reg[2];
        end
    end
    assign unit_start = (state_reg == S_ROLL || state_reg == S_PITCH) && !started_reg;

    tilt_angle_unit #(.CORDIC_STEPS(CORDIC_STEPS)) u_angle_unit (
        .aclk(aclk), .aresetn(aresetn), .start(unit_start), .num(u_num),
        .a_in(u_a), .b_in(u_b), .done(unit_done), .angle(u_angle)
    );

    logic signed [23:0] ang_diff;
    assign ang_diff = 24'(u_angle) - 24'((state_reg == S_ROLL) ? roll_err_reg : pitch_err_reg);

    // Shared filter multiply, roll then pitch.
    logic signed [FW-1:0] facc, fnew;
    logic signed [FW+1:0] fdiff;
    logic signed [FW+18:0] fprod;
    logic signed [FW-1:0] fround;
    always_comb begin
        facc = fsel_reg ? pacc_reg : racc_reg;
        fdiff = ((FW+2)'(fsel_reg ? pitch_reg : roll_reg) <<< E) - (FW+2)'(facc);
        fprod = (FW+19)'(fdiff) * $signed({1'b0, gain_reg});
        fnew = facc + FW'(fprod >>> 16);
        fround = (fnew + (FW'(1) <<< (E-1))) >>> E;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            started_reg <= 1'b0;
            racc_reg <= '0;
            pacc_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    raw_reg[0] <= s_tdata[12:0];
                    raw_reg[1] <= s_tdata[25:13];
                    raw_reg[2] <= s_tdata[38:26];
                    ax_reg <= 2'd0;
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    acc_reg[ax_reg] <= tilt_pkg::sat_acc(scaled);
                    if (ax_reg == 2'd2) state_reg <= S_ROLL;
                    ax_reg <= ax_reg + 2'd1;
                end
                S_ROLL: begin
                    started_reg <= 1'b1;
                    if (unit_done) begin
                        roll_reg <= tilt_pkg::sat_ang(ang_diff);
                        started_reg <= 1'b0;
                        state_reg <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    started_reg <= 1'b1;
                    if (unit_done) begin
                        pitch_reg <= tilt_pkg::sat_ang(ang_diff);
                        started_reg <= 1'b0;
                        fsel_reg <= 1'b0;
                        state_reg <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (!fsel_reg) begin
                        racc_reg <= fnew;
                        rs_reg <= tilt_pkg::sat_ang(24'(fround));
                        fsel_reg <= 1'b1;
                    end else begin
                        pacc_reg <= fnew;
                        ps_reg <= tilt_pkg::sat_ang(24'(fround));
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {6'd0, ps_reg, rs_reg, pitch_reg, roll_reg,
                      acc_reg[2], acc_reg[1], acc_reg[0]};

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_start |=> !unit_start) else $error("double unit start");
`endif
endmodule
